// ===== rtl/rrrl_pkg.sv =====
// Package for the round-robin run list unit.
// Request, status and slot mode codes. No dependencies.
`default_nettype none
package rrrl_pkg;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_mode;

    localparam t_func FN_ALLOC = 2'd0;
    localparam t_func FN_RUN   = 2'd1;
    localparam t_func FN_TICK  = 2'd2;
    localparam t_func FN_EXIT  = 2'd3;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_NO_SLOT     = 2'd1;
    localparam t_status ST_RUN_REFUSED = 2'd2;
    localparam t_status ST_EXIT_IGNORED = 2'd3;

    localparam t_mode MODE_FREE  = 2'd0;
    localparam t_mode MODE_ALLOC = 2'd1;
    localparam t_mode MODE_RUN   = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/round_robin_run_list_unit.sv =====
// Round-robin run list unit: slot allocation, run list append, tick and exit.
// Depends on rrrl_pkg and rrrl_ram (slot mode memory and run list memory).
`default_nettype none
// One request is taken at a time (start while busy is low); its result is
// shown for one cycle on o_valid and cannot be held off. Alloc, tick on a list
// of fewer than two tasks, and requests refused on slot range come back in the
// cycle after the request; run, tick and an exit of a slot that is not running
// wait on one memory read; an exit of a running slot waits on one memory read
// and then scans and compacts the run list memory one entry per cycle.
// After reset the unit is busy for one cycle while slot 0 is written into both
// memories. Free slots are tracked by a fill count, since slots are handed out
// lowest first and never freed.
module round_robin_run_list_unit
    import rrrl_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_func,
    input  wire logic [3:0] i_task_slot,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [3:0]      o_alloc_slot,
    output logic [3:0]      o_current_slot,
    output logic            o_switched,
    output logic [4:0]      o_running_count
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(SLOT_COUNT);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MODE = 3'd2;
    localparam logic [2:0] S_TICK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;

    logic [2:0]    r_state, n_state;
    t_func         r_func, n_func;
    logic [SW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_cur_pos, n_cur_pos;
    logic [SW-1:0] r_cur_slot, n_cur_slot;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_dat_idx, n_dat_idx;
    logic          r_found, n_found;
    logic [CW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_first, n_first;
    logic [SW-1:0] r_next, n_next;
    logic          r_valid, n_valid;
    t_status       r_status, n_status;
    logic [3:0]    r_alloc, n_alloc;
    logic          r_sw, n_sw;

    logic          mode_we;
    logic [SW-1:0] mode_waddr, mode_raddr;
    t_mode         mode_wdata, mode_rdata;
    logic          list_we;
    logic [SW-1:0] list_waddr, list_raddr, list_wdata, list_rdata;

    logic          c_slot_ok;
    logic [SW-1:0] c_slot_idx;
    logic [CW-1:0] c_pos_inc;
    logic [CW-1:0] c_cur_ext;
    logic [CW-1:0] c_newcount;
    logic          c_hit;
    logic          c_found;
    logic [CW-1:0] c_pos_f;
    logic [SW-1:0] c_first, c_next;

    rrrl_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_mode_ram (
        .i_clk   (i_clk),
        .i_we    (mode_we),
        .i_waddr (mode_waddr),
        .i_wdata (mode_wdata),
        .i_raddr (mode_raddr),
        .o_rdata (mode_rdata)
    );

    rrrl_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    assign busy = (r_state != S_IDLE);

    always_comb begin
        c_slot_ok  = ({28'd0, i_task_slot} < 32'(SLOT_COUNT)) &&
                     ({28'd0, i_task_slot} < 32'(r_fill));
        c_slot_idx = SW'(i_task_slot);
        c_cur_ext  = CW'(r_cur_pos);
        c_pos_inc  = c_cur_ext + CW'(1);
        c_newcount = r_count - CW'(1);
        c_hit      = !r_found && (list_rdata == r_slot);
        c_found    = r_found || c_hit;
        c_pos_f    = r_found ? r_pos : r_dat_idx;
        c_first    = (r_dat_idx == '0) ? list_rdata : r_first;
        c_next     = (r_dat_idx == c_pos_inc) ? list_rdata : r_next;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_slot     = r_slot;
        n_fill     = r_fill;
        n_count    = r_count;
        n_cur_pos  = r_cur_pos;
        n_cur_slot = r_cur_slot;
        n_rd_idx   = r_rd_idx;
        n_dat_idx  = r_dat_idx;
        n_found    = r_found;
        n_pos      = r_pos;
        n_first    = r_first;
        n_next     = r_next;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_alloc    = r_alloc;
        n_sw       = r_sw;
        mode_we    = 1'b0;
        mode_waddr = '0;
        mode_wdata = MODE_FREE;
        mode_raddr = c_slot_idx;
        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        list_raddr = '0;

        case (r_state)
            S_INIT: begin
                mode_we    = 1'b1;
                mode_wdata = MODE_RUN;
                list_we    = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_func   = i_func;
                    n_slot   = c_slot_idx;
                    n_status = ST_OK;
                    n_alloc  = '0;
                    n_sw     = 1'b0;
                    case (i_func)
                        FN_ALLOC: begin
                            n_valid = 1'b1;
                            if (r_fill < COUNT_MAX) begin
                                mode_we    = 1'b1;
                                mode_waddr = SW'(r_fill);
                                mode_wdata = MODE_ALLOC;
                                n_alloc    = 4'(r_fill);
                                n_fill     = r_fill + CW'(1);
                            end else begin
                                n_status = ST_NO_SLOT;
                            end
                        end
                        FN_RUN: begin
                            if (c_slot_ok) begin
                                n_state = S_MODE;
                            end else begin
                                n_status = ST_RUN_REFUSED;
                                n_valid  = 1'b1;
                            end
                        end
                        FN_TICK: begin
                            if (r_count >= CW'(2)) begin
                                n_cur_pos  = (c_pos_inc >= r_count) ? '0 : SW'(c_pos_inc);
                                list_raddr = n_cur_pos;
                                n_state    = S_TICK;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            if (c_slot_ok) begin
                                n_state = S_MODE;
                            end else begin
                                n_status = ST_EXIT_IGNORED;
                                n_valid  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_MODE: begin
                if (r_func == FN_RUN) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    if (mode_rdata == MODE_ALLOC && r_count < COUNT_MAX) begin
                        mode_we    = 1'b1;
                        mode_waddr = r_slot;
                        mode_wdata = MODE_RUN;
                        list_we    = 1'b1;
                        list_waddr = SW'(r_count);
                        list_wdata = r_slot;
                        n_count    = r_count + CW'(1);
                        if (r_count == '0) begin
                            n_cur_slot = r_slot;
                        end
                    end else begin
                        n_status = ST_RUN_REFUSED;
                    end
                end else begin
                    if (mode_rdata == MODE_RUN) begin
                        mode_we    = 1'b1;
                        mode_waddr = r_slot;
                        mode_wdata = MODE_ALLOC;
                        list_raddr = '0;
                        n_rd_idx   = CW'(1);
                        n_dat_idx  = '0;
                        n_found    = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        n_status = ST_EXIT_IGNORED;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_TICK: begin
                n_cur_slot = list_rdata;
                n_sw       = 1'b1;
                n_valid    = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                // read runs one entry ahead of the compacting write
                list_raddr = (r_rd_idx < r_count) ? SW'(r_rd_idx) : '0;
                n_rd_idx   = r_rd_idx + CW'(1);
                n_dat_idx  = r_dat_idx + CW'(1);
                n_first    = c_first;
                n_next     = c_next;
                if (c_hit) begin
                    n_found = 1'b1;
                    n_pos   = r_dat_idx;
                end
                if (r_found) begin
                    list_we    = 1'b1;
                    list_waddr = SW'(r_dat_idx - CW'(1));
                    list_wdata = list_rdata;
                end
                if (r_dat_idx == c_newcount) begin
                    n_count = c_newcount;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (!c_found) begin
                        n_status = ST_EXIT_IGNORED;
                        n_count  = r_count;
                    end else if (c_pos_f == c_cur_ext) begin
                        n_sw = (c_newcount != '0);
                        if (c_cur_ext >= c_newcount) begin
                            n_cur_pos  = '0;
                            n_cur_slot = (c_newcount == '0) ? '0 : c_first;
                        end else begin
                            n_cur_slot = c_next;
                        end
                    end else if (c_pos_f < c_cur_ext) begin
                        n_cur_pos = r_cur_pos - SW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_fill     <= CW'(1);
            r_count    <= CW'(1);
            r_cur_pos  <= '0;
            r_cur_slot <= '0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_cur_pos  <= n_cur_pos;
            r_cur_slot <= n_cur_slot;
            r_found    <= n_found;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_slot    <= n_slot;
        r_rd_idx  <= n_rd_idx;
        r_dat_idx <= n_dat_idx;
        r_pos     <= n_pos;
        r_first   <= n_first;
        r_next    <= n_next;
        r_status  <= n_status;
        r_alloc   <= n_alloc;
        r_sw      <= n_sw;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_alloc_slot    = r_alloc;
    assign o_current_slot  = 4'(r_cur_slot);
    assign o_switched      = r_sw;
    assign o_running_count = 5'(r_count);

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a request is in progress");

    a_pos_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) ? (r_cur_pos == '0) : (CW'(r_cur_pos) < r_count))
        else $error("current position outside the run list");

    a_running_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("more running tasks than allocated slots");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_ALLOC && r_fill < COUNT_MAX)
        |=> (o_valid && o_status == ST_OK && r_fill == $past(r_fill) + CW'(1)))
        else $error("alloc request with a free slot not granted");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_dat_idx < r_count))
        else $error("exit scan ran past the run list");

endmodule
`default_nettype wire

// ===== rtl/rrrl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module rrrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== tb/tb_round_robin_run_list_unit.sv =====
// Self-checking testbench for round_robin_run_list_unit: directed and random
// alloc, run, tick and exit requests, checked against an in-bench scheduler model.
// Depends on rrrl_pkg and the unit's RTL.
module tb_round_robin_run_list_unit
    import rrrl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    typedef struct packed {
        t_status    status;
        logic [3:0] alloc_slot;
        logic [3:0] current_slot;
        logic       switched;
        logic [4:0] running_count;
    } t_sched_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_func      i_func;
    logic [3:0] i_task_slot;
    logic       o_valid;
    logic [1:0] o_status;
    logic [3:0] o_alloc_slot;
    logic [3:0] o_current_slot;
    logic       o_switched;
    logic [4:0] o_running_count;

    // scheduler model state
    t_mode      slot_state [SLOTS];
    logic [3:0] run_order  [SLOTS];
    int         run_len;
    int         cur_idx;

    t_sched_result expected_results[$];
    int  mismatch_count;
    int  request_count;
    int  checked_count;
    int  empty_hits;
    int  full_hits;
    int  switch_hits;
    int  cycle_count;
    bit  steady_feed;

    round_robin_run_list_unit #(.SLOT_COUNT(SLOTS)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_task_slot     (i_task_slot),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_alloc_slot    (o_alloc_slot),
        .o_current_slot  (o_current_slot),
        .o_switched      (o_switched),
        .o_running_count (o_running_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [3:0] current_task();
        if (run_len == 0 || cur_idx >= run_len) begin
            return 4'd0;
        end
        return run_order[cur_idx];
    endfunction

    function automatic t_sched_result predict_request(input t_func fn, input logic [3:0] slot);
        t_sched_result r;
        int            pos;
        logic          was_current;
        r = '0;
        r.status = ST_OK;
        case (fn)
            FN_ALLOC: begin
                r.status = ST_NO_SLOT;
                for (int i = 0; i < SLOTS; i++) begin
                    if (r.status == ST_NO_SLOT && slot_state[i] == MODE_FREE) begin
                        slot_state[i] = MODE_ALLOC;
                        r.alloc_slot  = 4'(i);
                        r.status      = ST_OK;
                    end
                end
            end
            FN_RUN: begin
                if (slot_state[slot] != MODE_ALLOC || run_len >= SLOTS) begin
                    r.status = ST_RUN_REFUSED;
                end else begin
                    slot_state[slot]   = MODE_RUN;
                    run_order[run_len] = slot;
                    run_len++;
                    if (run_len == SLOTS) full_hits++;
                end
            end
            FN_TICK: begin
                if (run_len >= 2) begin
                    cur_idx    = (cur_idx + 1 >= run_len) ? 0 : cur_idx + 1;
                    r.switched = 1'b1;
                end
            end
            default: begin
                if (slot_state[slot] != MODE_RUN) begin
                    r.status = ST_EXIT_IGNORED;
                end else begin
                    was_current = (run_len > 0) && (current_task() == slot);
                    pos = run_len;
                    for (int i = 0; i < run_len; i++) begin
                        if (pos == run_len && run_order[i] == slot) pos = i;
                    end
                    if (pos < run_len) begin
                        run_len--;
                        if (pos < cur_idx) cur_idx--;
                        for (int i = pos; i < run_len; i++) begin
                            run_order[i] = run_order[i + 1];
                        end
                        slot_state[slot] = MODE_ALLOC;
                        if (was_current) begin
                            if (cur_idx >= run_len) cur_idx = 0;
                            if (run_len > 0) r.switched = 1'b1;
                        end
                        if (run_len == 0) empty_hits++;
                    end else begin
                        r.status = ST_EXIT_IGNORED;
                    end
                end
            end
        endcase
        r.current_slot  = current_task();
        r.running_count = run_len[4:0];
        if (r.switched) switch_hits++;
        return r;
    endfunction

    // random slot in the given mode, or any slot when none is in that mode
    function automatic logic [3:0] pick_slot(input t_mode m);
        logic [3:0] pool[$];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == m) pool.push_back(4'(i));
        end
        if (pool.size() == 0) begin
            return 4'($urandom_range(0, SLOTS - 1));
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task automatic send_request(input t_func fn, input logic [3:0] slot);
        int gap;
        gap = steady_feed ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= fn;
        i_task_slot <= slot;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_request(fn, slot));
        request_count++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && o_valid) begin
            got = {o_status, o_alloc_slot, o_current_slot, o_switched, o_running_count};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: status %0d alloc %0d cur %0d sw %0d count %0d",
                             got.status, got.alloc_slot, got.current_slot, got.switched,
                             got.running_count);
                end
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d mismatch (exp/got): status %0d/%0d alloc %0d/%0d",
                                 checked_count, want.status, got.status,
                                 want.alloc_slot, got.alloc_slot);
                        $display("    cur %0d/%0d switched %0d/%0d count %0d/%0d",
                                 want.current_slot, got.current_slot, want.switched,
                                 got.switched, want.running_count, got.running_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reset_unit();
        for (int i = 0; i < SLOTS; i++) begin
            slot_state[i] = MODE_FREE;
            run_order[i]  = 4'd0;
        end
        slot_state[0] = MODE_RUN;
        run_len       = 1;
        cur_idx       = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FN_ALLOC;
        i_task_slot <= 4'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // single entry list: tick, refused requests, emptying and refilling
    task automatic test_single_task_list();
        send_request(FN_TICK, 4'd0);
        send_request(FN_EXIT, 4'hF);
        send_request(FN_RUN,  4'd9);
        send_request(FN_RUN,  4'd0);
        send_request(FN_EXIT, 4'd0);
        send_request(FN_TICK, 4'd7);
        send_request(FN_EXIT, 4'd0);
        send_request(FN_RUN,  4'd0);
        send_request(FN_RUN,  4'd0);
    endtask

    task automatic test_alloc_run_tick();
        send_request(FN_ALLOC, 4'hF);
        send_request(FN_ALLOC, 4'd0);
        send_request(FN_EXIT,  4'd2);
        send_request(FN_RUN,   4'd1);
        send_request(FN_RUN,   4'd2);
        send_request(FN_TICK,  4'd0);
        send_request(FN_TICK,  4'd0);
        send_request(FN_TICK,  4'd0);
    endtask

    // exits before, after and at the current position, including the tail
    task automatic test_exit_positions();
        send_request(FN_ALLOC, 4'd0);
        send_request(FN_RUN,   4'd3);
        send_request(FN_TICK,  4'd0);
        send_request(FN_EXIT,  4'd0);
        send_request(FN_TICK,  4'd0);
        send_request(FN_TICK,  4'd0);
        send_request(FN_EXIT,  4'd3);
        send_request(FN_EXIT,  4'd2);
        wait_idle();
    endtask

    task automatic test_full_list();
        repeat (SLOTS) send_request(FN_ALLOC, 4'($urandom_range(0, 15)));
        while (run_len < SLOTS) send_request(FN_RUN, pick_slot(MODE_ALLOC));
        send_request(FN_RUN, 4'hF);
        steady_feed = 1'b1;
        repeat (SLOTS + 1) send_request(FN_TICK, 4'($urandom_range(0, 15)));
        steady_feed = 1'b0;
        send_request(FN_ALLOC, 4'd0);
    endtask

    task automatic test_random_traffic(input int count);
        int    done;
        int    bias;
        int    round_len;
        int    pick;
        int    run_w;
        int    exit_w;
        t_func fn;
        logic [3:0] slot;
        done = 0;
        while (done < count) begin
            bias        = $urandom_range(0, 2);
            round_len   = $urandom_range(40, 160);
            steady_feed = ($urandom_range(0, 3) == 0);
            run_w  = (bias == 0) ? 50 : (bias == 1) ? 15 : 30;
            exit_w = (bias == 0) ? 15 : (bias == 1) ? 50 : 30;
            for (int k = 0; k < round_len && done < count; k++) begin
                pick = $urandom_range(0, 99);
                slot = 4'($urandom_range(0, 15));
                if (pick < 5) begin
                    fn = FN_ALLOC;
                end else if (pick < 5 + run_w) begin
                    fn = FN_RUN;
                    if ($urandom_range(0, 9) < 7) slot = pick_slot(MODE_ALLOC);
                end else if (pick < 5 + run_w + exit_w) begin
                    fn = FN_EXIT;
                    if ($urandom_range(0, 9) < 8) slot = pick_slot(MODE_RUN);
                end else begin
                    fn = FN_TICK;
                end
                send_request(fn, slot);
                done++;
            end
            if ($urandom_range(0, 3) == 0) wait_idle();
        end
        steady_feed = 1'b0;
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests, checked %0d results, %0d switches.",
                 request_count, checked_count, switch_hits);
        $display("Run list emptied %0d times and filled %0d times; %0d mismatches.",
                 empty_hits, full_hits, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    endtask

    initial begin
        mismatch_count = 0;
        request_count  = 0;
        checked_count  = 0;
        empty_hits     = 0;
        full_hits      = 0;
        switch_hits    = 0;
        cycle_count    = 0;
        steady_feed    = 1'b0;
        reset_unit();
        test_single_task_list();
        test_alloc_run_tick();
        test_exit_positions();
        test_full_list();
        test_random_traffic(1900);
        finish_run();
    end

endmodule
